// ----- hw/rtl/tcgr_pkg.sv -----
package tcgr_pkg;

  // Sizes fixed by the item format
  localparam int SW_W       = 13;
  localparam int INDEX_W    = 24;
  localparam int COLOR_W    = 24;
  localparam int FONT_W     = 8;
  localparam int PIXELS     = 8;
  localparam int MAX_ROWS_OUT = 16;

  localparam int DEF_GLYPH_COUNT  = 256;
  localparam int DEF_GLYPH_HEIGHT = 16;

  localparam logic [SW_W-1:0] SW_RESET = 13'd1024;

  // Action codes
  localparam logic [1:0] ACT_LOAD = 2'd0;
  localparam logic [1:0] ACT_DRAW = 2'd1;
  localparam logic [1:0] ACT_MOVE = 2'd2;
  localparam logic [1:0] ACT_OFF  = 2'd3;

  localparam logic [2:0] COLOR_IDX_WHITE = 3'd7;

  localparam logic [COLOR_W-1:0] PAL_NORMAL [PIXELS] = '{
    24'h000000, 24'haa0000, 24'h00aa00, 24'haa5500,
    24'h0000aa, 24'haa00aa, 24'h00aaaa, 24'haaaaaa
  };
  localparam logic [COLOR_W-1:0] PAL_BRIGHT [PIXELS] = '{
    24'h555555, 24'hff5555, 24'h55ff55, 24'hffff55,
    24'h5555ff, 24'hff55ff, 24'h55ffff, 24'hffffff
  };

  localparam logic [COLOR_W-1:0] COLOR_BLACK     = 24'h000000;
  localparam logic [COLOR_W-1:0] COLOR_UNDERLINE = 24'haaaaaa;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SETUP,
    ST_RUN
  } state_t;

  // One pixel row on its way from the read stage to the output register
  typedef struct packed {
    logic [INDEX_W-1:0] idx;
    logic [COLOR_W-1:0] fg;
    logic [COLOR_W-1:0] bg;
    logic               use_font;
    logic               last;
  } row_t;

endpackage

// ----- hw/rtl/tcgr_font_mem.sv -----
module tcgr_font_mem #(
  parameter int DEPTH = tcgr_pkg::DEF_GLYPH_COUNT * tcgr_pkg::DEF_GLYPH_HEIGHT
) (
  input  logic                         clk,
  input  logic                         we,
  input  logic [$clog2(DEPTH)-1:0]     waddr,
  input  logic [tcgr_pkg::FONT_W-1:0]  wdata,
  input  logic                         re,
  input  logic [$clog2(DEPTH)-1:0]     raddr,
  output logic [tcgr_pkg::FONT_W-1:0]  rdata
);

  logic [tcgr_pkg::FONT_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- hw/rtl/tcgr_seq.sv -----
module tcgr_seq #(
  parameter int GLYPH_COUNT  = tcgr_pkg::DEF_GLYPH_COUNT,
  parameter int GLYPH_HEIGHT = tcgr_pkg::DEF_GLYPH_HEIGHT
) (
  input  logic                                              clk,
  input  logic                                              rst,
  input  logic                                              cfg_wr_en,
  input  logic [tcgr_pkg::SW_W-1:0]                         cfg_wr_data,
  input  logic                                              in_valid,
  output logic                                              in_stall,
  input  logic [1:0]                                        action,
  input  logic [7:0]                                        char_code,
  input  logic [3:0]                                        glyph_line,
  input  logic [7:0]                                        font_bits,
  input  logic [7:0]                                        cell_row,
  input  logic [8:0]                                        cell_col,
  input  logic [2:0]                                        fore_index,
  input  logic                                              fore_default,
  input  logic [2:0]                                        back_index,
  input  logic                                              back_default,
  input  logic                                              bold_on,
  input  logic                                              inverse_on,
  output logic                                              mem_we,
  output logic [$clog2(GLYPH_COUNT*GLYPH_HEIGHT)-1:0]       mem_waddr,
  output logic [tcgr_pkg::FONT_W-1:0]                       mem_wdata,
  output logic                                              mem_re,
  output logic [$clog2(GLYPH_COUNT*GLYPH_HEIGHT)-1:0]       mem_raddr,
  input  logic                                              out_free,
  output logic                                              rd_valid,
  output tcgr_pkg::row_t                                    rd_row
);

  localparam int ADDR_W = $clog2(GLYPH_COUNT * GLYPH_HEIGHT);
  localparam int LINE_W = $clog2(256 * GLYPH_HEIGHT);
  localparam int MUL_W  = LINE_W + tcgr_pkg::SW_W;
  localparam int ROWS   = (GLYPH_HEIGHT < tcgr_pkg::MAX_ROWS_OUT) ?
                          GLYPH_HEIGHT : tcgr_pkg::MAX_ROWS_OUT;
  localparam int ROWS_W = $clog2(ROWS + 1);
  localparam int Y_W    = $clog2(ROWS);

  tcgr_pkg::state_t state, state_next;

  logic [tcgr_pkg::SW_W-1:0]    sw;
  logic [7:0]                   cursor_row;
  logic [8:0]                   cursor_col;
  logic                         cursor_shown;
  logic                         pend;

  logic [ADDR_W-1:0]            glyph_base;
  logic [LINE_W-1:0]            seg_line;
  logic [8:0]                   seg_col;
  logic [ROWS_W-1:0]            seg_rows;
  logic                         seg_mem;
  logic [tcgr_pkg::COLOR_W-1:0] seg_fg;
  logic [tcgr_pkg::COLOR_W-1:0] seg_bg;
  logic [LINE_W-1:0]            pend_line;
  logic [8:0]                   pend_col;
  logic [tcgr_pkg::INDEX_W-1:0] idx;
  logic [Y_W-1:0]               y;

  logic                         in_accept;
  logic                         issue;
  logic                         seg_done;
  logic [9:0]                   code_ext;
  logic [9:0]                   code_mod;
  logic [ADDR_W-1:0]            glyph_base_in;
  logic                         line_ok;
  logic [LINE_W-1:0]            crow_line;
  logic [LINE_W-1:0]            new_ul_line;
  logic [LINE_W-1:0]            old_ul_line;
  logic [2:0]                   fsel;
  logic [tcgr_pkg::COLOR_W-1:0] fg_pick;
  logic [tcgr_pkg::COLOR_W-1:0] bg_pick;
  logic [tcgr_pkg::COLOR_W-1:0] fg_sel;
  logic [tcgr_pkg::COLOR_W-1:0] bg_sel;
  logic [MUL_W-1:0]             idx_prod;

  assign in_stall  = (state != tcgr_pkg::ST_IDLE);
  assign in_accept = in_valid && (state == tcgr_pkg::ST_IDLE);
  assign issue     = (state == tcgr_pkg::ST_RUN) && (!rd_valid || out_free);
  assign seg_done  = issue && (seg_rows == ROWS_W'(1));

  // Glyph number modulo GLYPH_COUNT: code stays below twice the count
  assign code_ext = {2'b00, char_code};
  assign code_mod = (code_ext >= 10'(GLYPH_COUNT)) ? code_ext - 10'(GLYPH_COUNT) : code_ext;
  assign glyph_base_in = ADDR_W'(ADDR_W'(code_mod) * ADDR_W'(GLYPH_HEIGHT));
  assign line_ok = ({2'b00, glyph_line} < 6'(GLYPH_HEIGHT));

  assign crow_line   = LINE_W'(LINE_W'(cell_row) * LINE_W'(GLYPH_HEIGHT));
  assign new_ul_line = crow_line + LINE_W'(GLYPH_HEIGHT - 1);
  assign old_ul_line = LINE_W'(LINE_W'(cursor_row) * LINE_W'(GLYPH_HEIGHT))
                       + LINE_W'(GLYPH_HEIGHT - 1);

  // Colour pick, then swap on inverse
  assign fsel    = fore_default ? tcgr_pkg::COLOR_IDX_WHITE : fore_index;
  assign fg_pick = bold_on ? tcgr_pkg::PAL_BRIGHT[fsel] : tcgr_pkg::PAL_NORMAL[fsel];
  assign bg_pick = back_default ? tcgr_pkg::COLOR_BLACK : tcgr_pkg::PAL_NORMAL[back_index];
  assign fg_sel  = inverse_on ? bg_pick : fg_pick;
  assign bg_sel  = inverse_on ? fg_pick : bg_pick;

  assign idx_prod = MUL_W'(seg_line) * MUL_W'(sw) + MUL_W'({seg_col, 3'b000});

  assign mem_we    = in_accept && (action == tcgr_pkg::ACT_LOAD) && line_ok;
  assign mem_waddr = glyph_base_in + ADDR_W'(glyph_line);
  assign mem_wdata = font_bits;
  assign mem_re    = issue && seg_mem;
  assign mem_raddr = glyph_base + ADDR_W'(y);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= tcgr_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      tcgr_pkg::ST_IDLE: begin
        if (in_accept && (action == tcgr_pkg::ACT_DRAW || action == tcgr_pkg::ACT_MOVE ||
                          (action == tcgr_pkg::ACT_OFF && cursor_shown))) begin
          state_next = tcgr_pkg::ST_SETUP;
        end
      end
      tcgr_pkg::ST_SETUP: begin
        state_next = tcgr_pkg::ST_RUN;
      end
      tcgr_pkg::ST_RUN: begin
        if (seg_done) begin
          state_next = pend ? tcgr_pkg::ST_SETUP : tcgr_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = tcgr_pkg::ST_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      sw           <= tcgr_pkg::SW_RESET;
      cursor_row   <= '0;
      cursor_col   <= '0;
      cursor_shown <= 1'b0;
      pend         <= 1'b0;
      rd_valid     <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        sw <= cfg_wr_data;
      end
      if (in_accept) begin
        unique case (action)
          tcgr_pkg::ACT_LOAD: begin
          end
          tcgr_pkg::ACT_DRAW: begin
            pend <= 1'b0;
          end
          tcgr_pkg::ACT_MOVE: begin
            pend         <= cursor_shown;
            cursor_row   <= cell_row;
            cursor_col   <= cell_col;
            cursor_shown <= 1'b1;
          end
          tcgr_pkg::ACT_OFF: begin
            pend         <= 1'b0;
            cursor_shown <= 1'b0;
          end
        endcase
      end else if (seg_done) begin
        pend <= 1'b0;
      end
      if (issue) begin
        rd_valid <= 1'b1;
      end else if (out_free) begin
        rd_valid <= 1'b0;
      end
    end
  end

  // Segment and read-stage payload
  always_ff @(posedge clk) begin
    if (in_accept) begin
      glyph_base <= glyph_base_in;
      pend_line  <= new_ul_line;
      pend_col   <= cell_col;
      seg_rows   <= ROWS_W'(1);
      seg_mem    <= 1'b0;
      seg_fg     <= tcgr_pkg::COLOR_BLACK;
      unique case (action)
        tcgr_pkg::ACT_LOAD: begin
        end
        tcgr_pkg::ACT_DRAW: begin
          seg_line <= crow_line;
          seg_col  <= cell_col;
          seg_rows <= ROWS_W'(ROWS);
          seg_mem  <= 1'b1;
          seg_fg   <= fg_sel;
          seg_bg   <= bg_sel;
        end
        tcgr_pkg::ACT_MOVE: begin
          // blank the old underline first when shown, else draw the new one
          seg_line <= cursor_shown ? old_ul_line : new_ul_line;
          seg_col  <= cursor_shown ? cursor_col : cell_col;
          seg_bg   <= cursor_shown ? tcgr_pkg::COLOR_BLACK : tcgr_pkg::COLOR_UNDERLINE;
        end
        tcgr_pkg::ACT_OFF: begin
          seg_line <= old_ul_line;
          seg_col  <= cursor_col;
          seg_bg   <= tcgr_pkg::COLOR_BLACK;
        end
      endcase
    end else if (state == tcgr_pkg::ST_SETUP) begin
      idx <= idx_prod[tcgr_pkg::INDEX_W-1:0];
      y   <= '0;
    end else if (issue) begin
      idx             <= idx + tcgr_pkg::INDEX_W'(sw);
      y               <= y + Y_W'(1);
      seg_rows        <= seg_rows - ROWS_W'(1);
      rd_row.idx      <= idx;
      rd_row.fg       <= seg_fg;
      rd_row.bg       <= seg_bg;
      rd_row.use_font <= seg_mem;
      rd_row.last     <= seg_done && !pend;
      if (seg_done && pend) begin
        seg_line <= pend_line;
        seg_col  <= pend_col;
        seg_rows <= ROWS_W'(1);
        seg_mem  <= 1'b0;
        seg_fg   <= tcgr_pkg::COLOR_BLACK;
        seg_bg   <= tcgr_pkg::COLOR_UNDERLINE;
      end
    end
  end

endmodule

// ----- hw/rtl/tcgr_out_stage.sv -----
module tcgr_out_stage (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                rd_valid,
  input  tcgr_pkg::row_t                      rd_row,
  input  logic [tcgr_pkg::FONT_W-1:0]         font_data,
  output logic                                out_free,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [tcgr_pkg::INDEX_W-1:0]        pixel_index,
  output logic [tcgr_pkg::COLOR_W-1:0]        pix [tcgr_pkg::PIXELS],
  output logic                                final_row
);

  logic [tcgr_pkg::FONT_W-1:0] bits;

  assign out_free = !out_valid || !out_stall;
  assign bits     = rd_row.use_font ? font_data : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= rd_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && rd_valid) begin
      pixel_index <= rd_row.idx;
      final_row   <= rd_row.last;
      for (int x = 0; x < tcgr_pkg::PIXELS; x++) begin
        pix[x] <= bits[tcgr_pkg::FONT_W-1-x] ? rd_row.fg : rd_row.bg;
      end
    end
  end

endmodule

// ----- hw/rtl/text_cell_glyph_renderer_core.sv -----
// Text cell renderer for 8-pixel-wide glyphs.
//
// Input channel (in_valid / in_stall) carries one command per transfer:
// font row load, character draw, cursor move or cursor off. Output channel
// (out_valid / out_stall) carries one pixel row per transfer: the framebuffer
// index of its leftmost pixel, eight 24-bit RGB pixels, and final_row on the
// last row caused by a command. cfg_wr_en / cfg_wr_data set the screen width
// (pixel row stride); write it only while the block is idle.
//
// Command flow: a font load gives no row and leaves the block idle. A draw
// passes a setup state for the row index multiply, then reads the font store
// once per row. A cursor command passes setup and run once per underline row.
// The first row passes setup, the read stage and the output register. The
// font store has one read port; one row is read per cycle unless stalled.
//
// Reset clears the cursor (hidden, at cell 0,0), the screen width (1024) and
// both channel stages; the font store keeps its contents. When the receiver
// stalls, the output register and the read stage hold and reads stop; a new
// command is taken as soon as the last row of the current one is read.
module text_cell_glyph_renderer_core #(
  parameter int GLYPH_COUNT  = tcgr_pkg::DEF_GLYPH_COUNT,
  parameter int GLYPH_HEIGHT = tcgr_pkg::DEF_GLYPH_HEIGHT
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_wr_en,
  input  logic [tcgr_pkg::SW_W-1:0]           cfg_wr_data,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [1:0]                          action,
  input  logic [7:0]                          char_code,
  input  logic [3:0]                          glyph_line,
  input  logic [7:0]                          font_bits,
  input  logic [7:0]                          cell_row,
  input  logic [8:0]                          cell_col,
  input  logic [2:0]                          fore_index,
  input  logic                                fore_default,
  input  logic [2:0]                          back_index,
  input  logic                                back_default,
  input  logic                                bold_on,
  input  logic                                inverse_on,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [tcgr_pkg::INDEX_W-1:0]        pixel_index,
  output logic [tcgr_pkg::COLOR_W-1:0]        pixel_a,
  output logic [tcgr_pkg::COLOR_W-1:0]        pixel_b,
  output logic [tcgr_pkg::COLOR_W-1:0]        pixel_c,
  output logic [tcgr_pkg::COLOR_W-1:0]        pixel_d,
  output logic [tcgr_pkg::COLOR_W-1:0]        pixel_e,
  output logic [tcgr_pkg::COLOR_W-1:0]        pixel_f,
  output logic [tcgr_pkg::COLOR_W-1:0]        pixel_g,
  output logic [tcgr_pkg::COLOR_W-1:0]        pixel_h,
  output logic                                final_row
);

  localparam int DEPTH  = GLYPH_COUNT * GLYPH_HEIGHT;
  localparam int ADDR_W = $clog2(DEPTH);

  // Font store write and read ports
  logic                         mem_we;
  logic [ADDR_W-1:0]            mem_waddr;
  logic [tcgr_pkg::FONT_W-1:0]  mem_wdata;
  logic                         mem_re;
  logic [ADDR_W-1:0]            mem_raddr;
  logic [tcgr_pkg::FONT_W-1:0]  mem_rdata;

  // Read stage between sequencer and output register
  logic                         rd_valid;
  tcgr_pkg::row_t               rd_row;
  logic                         out_free;
  logic [tcgr_pkg::COLOR_W-1:0] pix [tcgr_pkg::PIXELS];

  tcgr_font_mem #(
    .DEPTH(DEPTH)
  ) u_font_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // Sequencer: decode commands, keep cursor state, issue a row per free cycle
  tcgr_seq #(
    .GLYPH_COUNT  (GLYPH_COUNT),
    .GLYPH_HEIGHT (GLYPH_HEIGHT)
  ) u_seq (
    .clk          (clk),
    .rst          (rst),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .action       (action),
    .char_code    (char_code),
    .glyph_line   (glyph_line),
    .font_bits    (font_bits),
    .cell_row     (cell_row),
    .cell_col     (cell_col),
    .fore_index   (fore_index),
    .fore_default (fore_default),
    .back_index   (back_index),
    .back_default (back_default),
    .bold_on      (bold_on),
    .inverse_on   (inverse_on),
    .mem_we       (mem_we),
    .mem_waddr    (mem_waddr),
    .mem_wdata    (mem_wdata),
    .mem_re       (mem_re),
    .mem_raddr    (mem_raddr),
    .out_free     (out_free),
    .rd_valid     (rd_valid),
    .rd_row       (rd_row)
  );

  // Output register: expand glyph bits to colours, hold while stalled
  tcgr_out_stage u_out_stage (
    .clk         (clk),
    .rst         (rst),
    .rd_valid    (rd_valid),
    .rd_row      (rd_row),
    .font_data   (mem_rdata),
    .out_free    (out_free),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .pixel_index (pixel_index),
    .pix         (pix),
    .final_row   (final_row)
  );

  assign pixel_a = pix[0];
  assign pixel_b = pix[1];
  assign pixel_c = pix[2];
  assign pixel_d = pix[3];
  assign pixel_e = pix[4];
  assign pixel_f = pix[5];
  assign pixel_g = pix[6];
  assign pixel_h = pix[7];

  // A row in the read stage must hold while the output register is full
  assert property (@(posedge clk) disable iff (rst)
    rd_valid && !out_free |=> rd_valid && $stable(rd_row))
    else $error("read stage row lost or changed during output stall");

  // A new result only appears after a row sat in the read stage
  assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(rd_valid))
    else $error("output valid without a row from the read stage");

  // A draw always occupies the sequencer in the following cycle
  assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && action == tcgr_pkg::ACT_DRAW |=> in_stall)
    else $error("draw transfer did not start the sequencer");

endmodule

// ----- tb/sv/text_cell_glyph_renderer_core_tb.sv -----
`timescale 1ns / 100ps

module text_cell_glyph_renderer_core_tb;

  // Default build of the block: 256 glyphs of 16 rows, 16 rows out per draw
  localparam int GLYPH_ROWS = 16;
  localparam int GLYPHS = 256;
  // Cycles to let pass once the last pixel row is in, before a register write
  // or the final verdict
  localparam int SETTLE_CYCLES = 24;
  localparam int CYCLE_LIMIT = 400000;
  localparam int PHASE_ITEMS = 20;

  localparam bit [23:0] BASE_RGB [8] = '{
    24'h000000, 24'haa0000, 24'h00aa00, 24'haa5500,
    24'h0000aa, 24'haa00aa, 24'h00aaaa, 24'haaaaaa
  };
  localparam bit [23:0] BRIGHT_RGB [8] = '{
    24'h555555, 24'hff5555, 24'h55ff55, 24'hffff55,
    24'h5555ff, 24'hff55ff, 24'h55ffff, 24'hffffff
  };

  typedef enum int {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_PERIODIC} stall_mode_t;

  // One command as it goes over the input channel
  typedef struct packed {
    bit [1:0] act;
    bit [7:0] code;
    bit [3:0] line;
    bit [7:0] bits;
    bit [7:0] crow;
    bit [8:0] ccol;
    bit [2:0] fi;
    bit       fdef;
    bit [2:0] bi;
    bit       bdef;
    bit       bold;
    bit       inv;
  } cmd_t;

  // A command plus, for rows of the directed table, a hand-written outcome:
  // no row at all, or one row of a single colour
  typedef struct {
    cmd_t      c;
    bit        typed;
    bit        has_row;
    bit [23:0] exp_idx;
    bit [23:0] exp_rgb;
  } step_t;

  typedef struct packed {
    logic [23:0]      idx;
    logic [7:0][23:0] px;    // px[0] is the leftmost pixel
    logic             last;
  } pixel_row_t;

  logic clk;
  logic rst;
  logic cfg_wr_en;
  logic [tcgr_pkg::SW_W-1:0] cfg_wr_data;
  logic in_valid;
  logic in_stall;
  logic [1:0] action;
  logic [7:0] char_code;
  logic [3:0] glyph_line;
  logic [7:0] font_bits;
  logic [7:0] cell_row;
  logic [8:0] cell_col;
  logic [2:0] fore_index;
  logic fore_default;
  logic [2:0] back_index;
  logic back_default;
  logic bold_on;
  logic inverse_on;
  logic out_valid;
  logic out_stall;
  logic [tcgr_pkg::INDEX_W-1:0] pixel_index;
  logic [tcgr_pkg::COLOR_W-1:0] pixel_a, pixel_b, pixel_c, pixel_d;
  logic [tcgr_pkg::COLOR_W-1:0] pixel_e, pixel_f, pixel_g, pixel_h;
  logic final_row;

  text_cell_glyph_renderer_core uut (
    .clk(clk),
    .rst(rst),
    .cfg_wr_en(cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .action(action),
    .char_code(char_code),
    .glyph_line(glyph_line),
    .font_bits(font_bits),
    .cell_row(cell_row),
    .cell_col(cell_col),
    .fore_index(fore_index),
    .fore_default(fore_default),
    .back_index(back_index),
    .back_default(back_default),
    .bold_on(bold_on),
    .inverse_on(inverse_on),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .pixel_index(pixel_index),
    .pixel_a(pixel_a),
    .pixel_b(pixel_b),
    .pixel_c(pixel_c),
    .pixel_d(pixel_d),
    .pixel_e(pixel_e),
    .pixel_f(pixel_f),
    .pixel_g(pixel_g),
    .pixel_h(pixel_h),
    .final_row(final_row)
  );

  // Shadow of the block: font contents, underline cursor and row stride
  bit [7:0]  glyph_rows [GLYPHS][GLYPH_ROWS];
  bit [7:0]  ul_row;
  bit [8:0]  ul_col;
  bit        ul_shown;
  bit [12:0] line_stride;

  // Rows one command produces, then the rows still owed by the block
  pixel_row_t cmd_rows[$];
  pixel_row_t pending_rows[$];

  // Which font rows were ever loaded; only fully loaded glyphs get drawn
  bit [15:0] lines_loaded [GLYPHS];
  bit        glyph_ready [GLYPHS];
  bit [7:0]  ready_glyphs[$];

  int          err_count;
  int          rows_seen;
  int          burst_left;
  bit          valid_high;
  int unsigned cycle_count;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) cycle_count <= cycle_count + 1;

  // Hard stop for a hung block
  initial begin : watchdog
    wait (cycle_count >= CYCLE_LIMIT);
    $display("text_cell_glyph_renderer_core_tb: FAIL");
    $finish;
  end

  task automatic flag_error(input string msg);
    $display("ERROR @%0t: %s", $realtime, msg);
    err_count++;
  endtask

  // Framebuffer index of the leftmost pixel of glyph row y in a cell, mod 2^24
  function automatic bit [23:0] row_start(input bit [7:0] crow, input bit [8:0] ccol,
                                          input int unsigned y);
    bit [31:0] acc;
    acc = (32'(crow) * GLYPH_ROWS + y) * 32'(line_stride) + 32'(ccol) * 8;
    return acc[23:0];
  endfunction

  function automatic pixel_row_t make_row(input bit [23:0] idx, input bit [7:0] bits,
                                          input bit [23:0] on, input bit [23:0] off);
    pixel_row_t r;
    r.idx = idx;
    r.last = 1'b0;
    for (int x = 0; x < 8; x++) r.px[x] = bits[7-x] ? on : off;
    return r;
  endfunction

  // Update the shadow with one command and fill cmd_rows with the rows it gives
  function automatic void render_command(input cmd_t c);
    bit [2:0]  fsel;
    bit [23:0] fg, bg, swap;
    cmd_rows.delete();
    case (c.act)
      tcgr_pkg::ACT_LOAD: begin
        if (c.line < GLYPH_ROWS) glyph_rows[c.code][c.line] = c.bits;
      end
      tcgr_pkg::ACT_DRAW: begin
        fsel = c.fdef ? tcgr_pkg::COLOR_IDX_WHITE : c.fi;
        fg = c.bold ? BRIGHT_RGB[fsel] : BASE_RGB[fsel];
        bg = c.bdef ? BASE_RGB[0] : BASE_RGB[c.bi];
        if (c.inv) begin
          swap = fg;
          fg = bg;
          bg = swap;
        end
        for (int y = 0; y < GLYPH_ROWS; y++)
          cmd_rows.push_back(make_row(row_start(c.crow, c.ccol, y), glyph_rows[c.code][y],
                                      fg, bg));
      end
      default: begin
        // Blank the old underline first, if there is one
        if (ul_shown)
          cmd_rows.push_back(make_row(row_start(ul_row, ul_col, GLYPH_ROWS - 1), 8'h00,
                                      24'h0, BASE_RGB[0]));
        if (c.act == tcgr_pkg::ACT_MOVE) begin
          ul_row = c.crow;
          ul_col = c.ccol;
          ul_shown = 1'b1;
          cmd_rows.push_back(make_row(row_start(c.crow, c.ccol, GLYPH_ROWS - 1), 8'h00,
                                      24'h0, BASE_RGB[7]));
        end else begin
          ul_shown = 1'b0;
        end
      end
    endcase
    if (cmd_rows.size() > 0) cmd_rows[cmd_rows.size()-1].last = 1'b1;
  endfunction

  function automatic step_t fresh_step(input bit [1:0] act);
    step_t s;
    bit [63:0] r;
    r = {$urandom, $urandom};
    s.c = cmd_t'(r[$bits(cmd_t)-1:0]);
    s.c.act = act;
    s.typed = 1'b0;
    s.has_row = 1'b0;
    s.exp_idx = '0;
    s.exp_rgb = '0;
    return s;
  endfunction

  // Sender pacing: bursts of random length, random gaps between them
  task automatic pace_sender();
    int gap;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_valid <= 1'b0;
        valid_high = 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 40) : $urandom_range(0, 6);
    end
  endtask

  // Present one command, hold it until the transfer, then book its rows
  task automatic issue_cmd(input step_t s);
    pixel_row_t r;
    in_valid     <= 1'b1;
    valid_high    = 1'b1;
    action       <= s.c.act;
    char_code    <= s.c.code;
    glyph_line   <= s.c.line;
    font_bits    <= s.c.bits;
    cell_row     <= s.c.crow;
    cell_col     <= s.c.ccol;
    fore_index   <= s.c.fi;
    fore_default <= s.c.fdef;
    back_index   <= s.c.bi;
    back_default <= s.c.bdef;
    bold_on      <= s.c.bold;
    inverse_on   <= s.c.inv;
    @(posedge clk);
    while (in_stall !== 1'b0) @(posedge clk);
    render_command(s.c);
    if (s.typed) begin
      // Hand-written outcome replaces the computed one
      cmd_rows.delete();
      if (s.has_row) begin
        r = make_row(s.exp_idx, 8'h00, 24'h0, s.exp_rgb);
        r.last = 1'b1;
        cmd_rows.push_back(r);
      end
    end
    foreach (cmd_rows[i]) pending_rows.push_back(cmd_rows[i]);
    if (s.c.act == tcgr_pkg::ACT_LOAD && s.c.line < GLYPH_ROWS) begin
      lines_loaded[s.c.code][s.c.line] = 1'b1;
      if (&lines_loaded[s.c.code] && !glyph_ready[s.c.code]) begin
        glyph_ready[s.c.code] = 1'b1;
        ready_glyphs.push_back(s.c.code);
      end
    end
    pace_sender();
  endtask

  // Drop valid and hold off until every owed row is in and the block is quiet
  task automatic quiesce();
    if (valid_high) begin
      in_valid <= 1'b0;
      valid_high = 1'b0;
    end
    while (pending_rows.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Screen width is only written while the block is idle
  task automatic set_stride(input bit [12:0] w);
    quiesce();
    cfg_wr_data <= w;
    cfg_wr_en   <= 1'b1;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    line_stride  = w;
  endtask

  task automatic random_traffic(input int quota);
    int    done;
    int    pick;
    step_t s;
    bit [7:0] g;
    done = 0;
    while (done < quota) begin
      pick = $urandom_range(0, 99);
      if (pick < 6) begin
        // Well-formed sequence: load a whole glyph, then draw it
        g = 8'($urandom_range(0, 255));
        for (int l = 0; l < GLYPH_ROWS; l++) begin
          s = fresh_step(tcgr_pkg::ACT_LOAD);
          s.c.code = g;
          s.c.line = l[3:0];
          issue_cmd(s);
        end
        s = fresh_step(tcgr_pkg::ACT_DRAW);
        s.c.code = g;
        issue_cmd(s);
        done += GLYPH_ROWS + 1;
      end else begin
        if (pick < 20) begin
          s = fresh_step(tcgr_pkg::ACT_LOAD);
        end else if (pick < 60) begin
          s = fresh_step(tcgr_pkg::ACT_DRAW);
          s.c.code = ready_glyphs[$urandom_range(0, ready_glyphs.size() - 1)];
        end else if (pick < 82) begin
          s = fresh_step(tcgr_pkg::ACT_MOVE);
        end else begin
          s = fresh_step(tcgr_pkg::ACT_OFF);
        end
        issue_cmd(s);
        done++;
      end
    end
  endtask

  // Receiver: stalls on a pattern of its own, switching style every so often
  initial begin : receiver
    stall_mode_t mode;
    int span;
    out_stall <= 1'b0;
    forever begin
      mode = stall_mode_t'($urandom_range(0, 3));
      span = $urandom_range(16, 96);
      for (int k = 0; k < span; k++) begin
        @(posedge clk);
        case (mode)
          STALL_NONE:  out_stall <= 1'b0;
          STALL_LIGHT: out_stall <= ($urandom_range(0, 99) < 30);
          STALL_HEAVY: out_stall <= ($urandom_range(0, 99) < 80);
          default:     out_stall <= ((k % 12) < 7);
        endcase
      end
    end
  end

  // Compare every transfer on the output side with the oldest owed row
  always @(posedge clk) begin : row_check
    pixel_row_t got, want;
    if (rst === 1'b0 && out_valid === 1'b1 && out_stall === 1'b0) begin
      got.idx  = pixel_index;
      got.px   = {pixel_h, pixel_g, pixel_f, pixel_e, pixel_d, pixel_c, pixel_b, pixel_a};
      got.last = final_row;
      if (pending_rows.size() == 0) begin
        flag_error($sformatf("row %0d not owed: index %h", rows_seen, pixel_index));
      end else begin
        want = pending_rows.pop_front();
        if (got.idx !== want.idx)
          flag_error($sformatf("row %0d pixel_index %h, want %h", rows_seen, got.idx, want.idx));
        for (int x = 0; x < 8; x++)
          if (got.px[x] !== want.px[x])
            flag_error($sformatf("row %0d pixel %0d colour %h, want %h", rows_seen, x,
                                 got.px[x], want.px[x]));
        if (got.last !== want.last)
          flag_error($sformatf("row %0d final_row %b, want %b", rows_seen, got.last, want.last));
      end
      rows_seen++;
    end
  end

  initial begin : stimulus
    step_t plan[$];
    step_t s;
    rst          <= 1'b1;
    cfg_wr_en    <= 1'b0;
    cfg_wr_data  <= '0;
    in_valid     <= 1'b0;
    action       <= tcgr_pkg::ACT_LOAD;
    char_code    <= '0;
    glyph_line   <= '0;
    font_bits    <= '0;
    cell_row     <= '0;
    cell_col     <= '0;
    fore_index   <= '0;
    fore_default <= 1'b0;
    back_index   <= '0;
    back_default <= 1'b0;
    bold_on      <= 1'b0;
    inverse_on   <= 1'b0;
    line_stride   = tcgr_pkg::SW_RESET;
    ul_row        = '0;
    ul_col        = '0;
    ul_shown      = 1'b0;

    // Directed table. Cursor off while hidden gives nothing
    s = fresh_step(tcgr_pkg::ACT_OFF);
    s.typed = 1'b1;
    plan.push_back(s);
    // First move from hidden: one underline at (0*16+15)*1024
    s = fresh_step(tcgr_pkg::ACT_MOVE);
    s.c.crow = 8'd0;
    s.c.ccol = 9'd0;
    s.typed = 1'b1;
    s.has_row = 1'b1;
    s.exp_idx = 24'd15360;
    s.exp_rgb = 24'haaaaaa;
    plan.push_back(s);
    // Glyph 255 in full: blank row, solid row, leftmost and rightmost pixel
    for (int l = 0; l < GLYPH_ROWS; l++) begin
      s = fresh_step(tcgr_pkg::ACT_LOAD);
      s.c.code = 8'hff;
      s.c.line = l[3:0];
      case (l)
        0: s.c.bits = 8'h00;
        1: s.c.bits = 8'hff;
        2: s.c.bits = 8'h80;
        3: s.c.bits = 8'h01;
        default: ;
      endcase
      plan.push_back(s);
    end
    // Lowest glyph code, partial load only
    s = fresh_step(tcgr_pkg::ACT_LOAD);
    s.c.code = 8'h00;
    s.c.line = 4'd0;
    s.c.bits = 8'hff;
    plan.push_back(s);
    // Draws: plain, bold default fg on default bg at the far cell, inverse
    s = fresh_step(tcgr_pkg::ACT_DRAW);
    s.c.code = 8'hff;
    s.c.crow = 8'd0;
    s.c.ccol = 9'd0;
    {s.c.fi, s.c.fdef, s.c.bi, s.c.bdef, s.c.bold, s.c.inv} = {3'd7, 1'b0, 3'd0, 3'b000};
    plan.push_back(s);
    s = fresh_step(tcgr_pkg::ACT_DRAW);
    s.c.code = 8'hff;
    s.c.crow = 8'd255;
    s.c.ccol = 9'd511;
    {s.c.fi, s.c.fdef, s.c.bi, s.c.bdef, s.c.bold, s.c.inv} = {3'd2, 1'b1, 3'd6, 3'b110};
    plan.push_back(s);
    s = fresh_step(tcgr_pkg::ACT_DRAW);
    s.c.code = 8'hff;
    s.c.crow = 8'd17;
    s.c.ccol = 9'd300;
    {s.c.fi, s.c.fdef, s.c.bi, s.c.bdef, s.c.bold, s.c.inv} = {3'd0, 1'b0, 3'd7, 3'b001};
    plan.push_back(s);
    s = fresh_step(tcgr_pkg::ACT_DRAW);
    s.c.code = 8'hff;
    s.c.crow = 8'd128;
    s.c.ccol = 9'd256;
    {s.c.fi, s.c.fdef, s.c.bi, s.c.bdef, s.c.bold, s.c.inv} = {3'd3, 1'b1, 3'd5, 3'b001};
    plan.push_back(s);
    // Move while shown blanks the old cell; a move to the same cell does it again
    s = fresh_step(tcgr_pkg::ACT_MOVE);
    s.c.crow = 8'd255;
    s.c.ccol = 9'd511;
    plan.push_back(s);
    plan.push_back(s);
    // Off while shown: one black underline at (255*16+15)*1024 + 511*8
    s = fresh_step(tcgr_pkg::ACT_OFF);
    s.typed = 1'b1;
    s.has_row = 1'b1;
    s.exp_idx = 24'd4197368;
    s.exp_rgb = 24'h000000;
    plan.push_back(s);
    s = fresh_step(tcgr_pkg::ACT_OFF);
    s.typed = 1'b1;
    plan.push_back(s);

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    foreach (plan[i]) issue_cmd(plan[i]);

    // Random phases, each at its own stride; the sender fully drains before
    // every register write. Zero and the 13-bit maximum are out of the usual
    // range but still used as the stride, and the latter wraps the index.
    set_stride(13'd8);
    random_traffic(PHASE_ITEMS);
    set_stride(13'd4096);
    random_traffic(PHASE_ITEMS);
    set_stride(13'd8191);
    random_traffic(PHASE_ITEMS);
    set_stride(13'd0);
    random_traffic(PHASE_ITEMS);
    set_stride(13'($urandom_range(8, 4096)));
    random_traffic(PHASE_ITEMS);

    quiesce();
    if (err_count == 0) begin
      $display("text_cell_glyph_renderer_core_tb: PASS");
    end else begin
      $display("text_cell_glyph_renderer_core_tb: FAIL");
    end
    $finish;
  end

endmodule

// ----- files.f -----
hw/rtl/tcgr_pkg.sv
hw/rtl/tcgr_font_mem.sv
hw/rtl/tcgr_seq.sv
hw/rtl/tcgr_out_stage.sv
hw/rtl/text_cell_glyph_renderer_core.sv
tb/sv/text_cell_glyph_renderer_core_tb.sv
